FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files; only skst_dp includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, switched off while reset is asserted
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/skst_pkg.sv
// types and constants of the sorted key sum table
`default_nettype none

package skst_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned AmtW    = 16;
  localparam int unsigned CntW    = 32;
  localparam int unsigned SumW    = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 104;

  typedef enum logic {
    OP_LOG  = 1'b0,
    OP_DUMP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_UPD   = 2'd1,
    WR_SHIFT = 2'd2,
    WR_NEW   = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [CntW-1:0] cnt;
    logic [SumW-1:0] sum;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    rd;
    logic    rd_prev;
    logic    idx_inc;
    logic    idx_dec;
    logic    start_shift;
    wr_sel_e wr_sel;
    logic    used_inc;
    logic    out_load;
    kind_e   out_kind;
    status_e status;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic key_lt;
    logic key_eq;
    logic idx_last;
    logic used_zero;
    logic full;
    logic idx_gt_pos;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/skst_dp.sv
// datapath: entry memory, index counters, saturating update and result register
`default_nettype none

module skst_dp #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire skst_pkg::cmd_t             cmd_i,
  output skst_pkg::stat_t                 stat_o,
  input  wire [skst_pkg::KeyW-1:0]        key_i,
  input  wire [skst_pkg::AmtW-1:0]        amount_i,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output skst_pkg::kind_e                 out_kind_o,
  output skst_pkg::status_e               out_status_o,
  output logic [skst_pkg::KeyW-1:0]       out_key_o,
  output logic [skst_pkg::CntW-1:0]       out_cnt_o,
  output logic [skst_pkg::SumW-1:0]       out_sum_o,
  output logic                            out_last_o
);

  `include "assert_macros.svh"

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UseW = $clog2(ENTRIES + 1);

  skst_pkg::entry_t mem [ENTRIES];
  skst_pkg::entry_t rdata_q;
  skst_pkg::entry_t wdata;

  logic [UseW-1:0]           used_q, idx_q, pos_q, idx_m1, idx_p1;
  logic [skst_pkg::KeyW-1:0] key_q;
  logic [skst_pkg::AmtW-1:0] amt_q;
  logic [IdxW-1:0]           raddr;
  logic                      we;
  logic [skst_pkg::SumW:0]   sum_wide;
  logic                      out_valid_q;
  skst_pkg::kind_e           out_kind_q;
  skst_pkg::status_e         out_status_q;
  skst_pkg::entry_t          out_entry_q;
  logic                      out_last_q;

  assign idx_m1 = idx_q - UseW'(1);
  assign idx_p1 = idx_q + UseW'(1);
  assign raddr  = cmd_i.rd_prev ? idx_m1[IdxW-1:0] : idx_q[IdxW-1:0];
  assign sum_wide = {1'b0, rdata_q.sum} + (skst_pkg::SumW+1)'(amt_q);

  always_comb begin
    wdata = rdata_q;
    we    = 1'b1;
    case (cmd_i.wr_sel)
      skst_pkg::WR_UPD: begin
        wdata.cnt = (&rdata_q.cnt) ? rdata_q.cnt : rdata_q.cnt + skst_pkg::CntW'(1);
        wdata.sum = sum_wide[skst_pkg::SumW] ? {skst_pkg::SumW{1'b1}}
                                             : sum_wide[skst_pkg::SumW-1:0];
      end
      skst_pkg::WR_SHIFT: begin
        wdata = rdata_q;
      end
      skst_pkg::WR_NEW: begin
        wdata.key = key_q;
        wdata.cnt = skst_pkg::CntW'(1);
        wdata.sum = skst_pkg::SumW'(amt_q);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q[IdxW-1:0]] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= key_i;
      amt_q <= amount_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      idx_q  <= '0;
      pos_q  <= '0;
    end else begin
      if (cmd_i.used_inc) begin
        used_q <= used_q + UseW'(1);
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.start_shift) begin
        pos_q <= idx_q;
        idx_q <= used_q;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_p1;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_m1;
      end
    end
  end

  // result register parts the datapath from the output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q   <= cmd_i.out_kind;
      out_status_q <= (cmd_i.out_kind == skst_pkg::KIND_ACK) ? cmd_i.status
                                                            : skst_pkg::ST_INSERTED;
      out_entry_q  <= (cmd_i.out_kind == skst_pkg::KIND_ENTRY) ? rdata_q : '0;
      out_last_q   <= (cmd_i.out_kind == skst_pkg::KIND_ENTRY) ? (idx_p1 == used_q) : 1'b1;
    end
  end

  assign stat_o.key_lt     = rdata_q.key < key_q;
  assign stat_o.key_eq     = rdata_q.key == key_q;
  assign stat_o.idx_last   = idx_p1 == used_q;
  assign stat_o.used_zero  = used_q == '0;
  assign stat_o.full       = used_q == UseW'(ENTRIES);
  assign stat_o.idx_gt_pos = idx_q > pos_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_entry_q.key;
  assign out_cnt_o    = out_entry_q.cnt;
  assign out_sum_o    = out_entry_q.sum;
  assign out_last_o   = out_last_q;

  `ASSERT_RST(a_used_bound, used_q <= UseW'(ENTRIES), "entry count beyond table size")
  `ASSERT_RST(a_no_grow_full, cmd_i.used_inc |-> used_q < UseW'(ENTRIES),
              "insert into a full table")
  `ASSERT_RST(a_load_free, cmd_i.out_load |-> (!out_valid_q || out_ready_i),
              "result overwritten before it was taken")
  `ASSERT_RST(a_wr_in_range, (cmd_i.wr_sel != skst_pkg::WR_NONE) |-> idx_q < UseW'(ENTRIES),
              "write beyond table")

endmodule

`default_nettype wire

FILE: rtl/core/skst_ctrl.sv
// controller: sequences search, shift, update and dump over the entry memory
`default_nettype none

module skst_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_opcode_i,
  output logic                 in_ready_o,
  input  wire skst_pkg::stat_t stat_i,
  output skst_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LRD,
    S_LCMP,
    S_INS,
    S_SHCHK,
    S_SHWR,
    S_ACK,
    S_DRD,
    S_DOUT,
    S_EMPTY
  } state_e;

  state_e            state_q, state_d;
  skst_pkg::status_e status_q, status_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o          = '0;
    cmd_o.wr_sel   = skst_pkg::WR_NONE;
    cmd_o.out_kind = skst_pkg::KIND_ACK;
    cmd_o.status   = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_opcode_i == skst_pkg::OP_LOG) begin
            state_d = stat_i.used_zero ? S_INS : S_LRD;
          end else begin
            state_d = stat_i.used_zero ? S_EMPTY : S_DRD;
          end
        end
      end
      S_LRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LCMP;
      end
      S_LCMP: begin
        if (stat_i.key_eq) begin
          cmd_o.wr_sel = skst_pkg::WR_UPD;
          status_d     = skst_pkg::ST_UPDATED;
          state_d      = S_ACK;
        end else if (stat_i.key_lt) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.idx_last ? S_INS : S_LRD;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (stat_i.full) begin
          status_d = skst_pkg::ST_FULL;
          state_d  = S_ACK;
        end else begin
          cmd_o.start_shift = 1'b1;
          state_d           = S_SHCHK;
        end
      end
      S_SHCHK: begin
        if (stat_i.idx_gt_pos) begin
          cmd_o.rd      = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SHWR;
        end else begin
          cmd_o.wr_sel   = skst_pkg::WR_NEW;
          cmd_o.used_inc = 1'b1;
          status_d       = skst_pkg::ST_INSERTED;
          state_d        = S_ACK;
        end
      end
      S_SHWR: begin
        cmd_o.wr_sel  = skst_pkg::WR_SHIFT;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_SHCHK;
      end
      S_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = skst_pkg::KIND_ACK;
          state_d        = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DOUT;
      end
      S_DOUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = skst_pkg::KIND_ENTRY;
          if (stat_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_DRD;
          end
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = skst_pkg::KIND_EMPTY;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= skst_pkg::ST_INSERTED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_key_sum_table_unit.sv
// top level of the sorted key sum table: stream ports, controller and datapath
//
//   channel  dir  beat contents
//   s_axis   in   tuser opcode, tdata key_in and amount
//   m_axis   out  tuser kind, tdata status/key/count/sum, tlast last
//
// log, from the accepting edge to the loaded result: a memory read and a compare per entry
//   compared, one memory access a cycle, then an update write, or a full-table drop, or for
//   an insert a move up of each later entry (a read and a write each) and the new entry
// dump: one memory read then the beat for each entry; a single empty beat for an empty table
// one item at a time; s_axis_tready is high only while the controller is idle
// reset empties the table at once; a stalled m_axis holds the result register
`default_nettype none

module sorted_key_sum_table_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] key_in, [47:32] amount
  input  wire [skst_pkg::InDataW-1:0]        s_axis_tdata,
  // [0] opcode
  input  wire                                s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [1:0] status, [33:2] key_out, [65:34] count_out, [97:66] sum_out, zero above
  output logic [skst_pkg::OutDataW-1:0]      m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  skst_pkg::cmd_t            cmd;
  skst_pkg::stat_t           stat;
  skst_pkg::kind_e           out_kind;
  skst_pkg::status_e         out_status;
  logic [skst_pkg::KeyW-1:0] out_key;
  logic [skst_pkg::CntW-1:0] out_cnt;
  logic [skst_pkg::SumW-1:0] out_sum;

  skst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  skst_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_i        (s_axis_tdata[31:0]),
    .amount_i     (s_axis_tdata[47:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (out_kind),
    .out_status_o (out_status),
    .out_key_o    (out_key),
    .out_cnt_o    (out_cnt),
    .out_sum_o    (out_sum),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_sum, out_cnt, out_key, out_status};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
